>>> sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types, constants and a function of the sine tone generator
// Field widths, register codes, memory slot map, sequencer states and the
// quarter-wave sine table generator used by the lookup stage.
// ----------------------------------------------------------------------------
package sts_pkg;

   // default parameter values
   localparam int unsigned SINE_TABLE_BITS_DEF = 8;
   localparam int unsigned PHASE_BITS_DEF      = 32;

   // field widths
   localparam int unsigned RATE_BITS   = 17;
   localparam int unsigned AMP_BITS    = 15;
   localparam int unsigned FREQ_BITS   = 15;
   localparam int unsigned DUR_BITS    = 16;
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned COUNT_BITS  = 23;
   localparam int unsigned MAG_BITS    = 15;

   // register port
   localparam int unsigned ADDR_BITS = 3;
   localparam int unsigned DATA_BITS = 32;

   // register reset values and fixed numbers
   localparam logic [RATE_BITS-1:0]  RATE_RESET = 17'd44100;
   localparam logic [AMP_BITS-1:0]   AMP_RESET  = 15'd19661;
   localparam logic [MAG_BITS-1:0]   FULL_SCALE = 15'd32767;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 23'd8388607;
   localparam longint unsigned       PI_HALF_Q30 = 64'd1686629713;

   // divide by 1000 ms per second: shift by 3, then reciprocal multiply by 1/125
   localparam int unsigned           MS_SHIFT    = 3;
   localparam int unsigned           RECIP_BITS  = 31;
   localparam int unsigned           RECIP_SHIFT = 37;
   localparam logic [RECIP_BITS-1:0] RECIP_125   = 31'd1099511628;

   // state memory: one word per state variable
   localparam int unsigned RAM_DEPTH = 3;
   localparam int unsigned RAM_AW    = 2;

   typedef enum logic [RAM_AW-1:0] {
      SLOT_ACC  = 2'd0,
      SLOT_STEP = 2'd1,
      SLOT_CNT  = 2'd2
   } slot_type;

   typedef enum logic {
      REG_RATE = 1'b0,
      REG_AMP  = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_START  = 1'b1
   } cmd_type;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_RD_ACC   = 11'b000_0000_0010,
      ST_RD_STEP  = 11'b000_0000_0100,
      ST_UPD      = 11'b000_0000_1000,
      ST_WR_CNT   = 11'b000_0001_0000,
      ST_OUT      = 11'b000_0010_0000,
      ST_CNT_GO   = 11'b000_0100_0000,
      ST_DIV_CNT  = 11'b000_1000_0000,
      ST_STEP_GO  = 11'b001_0000_0000,
      ST_DIV_STEP = 11'b010_0000_0000,
      ST_WR_ACC   = 11'b100_0000_0000
   } state_type;

   // quarter-wave entry: 32767*sin(pi/2*idx/2^tbits), Q30 taylor series to x^17
   function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned idx,
                                                        input int unsigned tbits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      if (idx >= (32'd1 << tbits)) begin
         return FULL_SCALE;
      end
      x    = (64'(idx) * PI_HALF_Q30) >> tbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 8; k++) begin
         term = (term * x2) >> 30;
         unique case (k)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            7:       term = term / 64'd210;
            default: term = term / 64'd272;
         endcase
         if ((k & 1) == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
      return (v > 64'd32767) ? FULL_SCALE : v[MAG_BITS-1:0];
   endfunction

endpackage

>>> sv/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram: generic single-write, single-read synchronous memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sts_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sts_div.sv
// ----------------------------------------------------------------------------
// sts_div: iterative restoring divider
// One quotient bit per cycle; done pulses as the last bit is registered, and
// the quotient holds until the next start.
// ----------------------------------------------------------------------------
module sts_div #(
   parameter int unsigned DW = 47,
   parameter int unsigned VW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int unsigned CW = $clog2(DW + 1);

   logic [DW-1:0] quot_ff, quot_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] iter_ff, iter_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          fits;

   // one restoring step: shift in next dividend bit, subtract if it fits
   assign trial = {rem_ff, quot_ff[DW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         iter_in = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DW-2:0], fits};
         rem_in  = fits ? diff[VW-1:0] : trial[VW-1:0];
         iter_in = iter_ff - 1'b1;
         busy_in = (iter_ff != CW'(1));
         done_in = (iter_ff == CW'(1));
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         iter_ff <= iter_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> sv/sts_sine.sv
// ----------------------------------------------------------------------------
// sts_sine: quarter-wave sine lookup and amplitude scaling
// Table read registered, then amplitude multiply registered; the sample is
// valid once both are loaded and holds until a new lookup or amplitude.
// ----------------------------------------------------------------------------
module sts_sine #(
   parameter int unsigned TABLE_BITS = sts_pkg::SINE_TABLE_BITS_DEF,
   parameter int unsigned PHASE_BITS = sts_pkg::PHASE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    lookup,
   input  logic [PHASE_BITS-1:0]                   phase,
   input  logic [sts_pkg::AMP_BITS-1:0]            amplitude,
   output logic signed [sts_pkg::SAMPLE_BITS-1:0]  sample
);

   import sts_pkg::*;

   localparam int unsigned TableSize = 2 ** TABLE_BITS;
   localparam int unsigned TAW       = TABLE_BITS + 1;
   localparam int unsigned ProdBits  = MAG_BITS + AMP_BITS;

   logic [MAG_BITS-1:0]   rom [TableSize + 1];
   logic [1:0]            quad;
   logic [TABLE_BITS-1:0] idx;
   logic [TAW-1:0]        rom_addr;
   logic [MAG_BITS-1:0]   mag_ff;
   logic                  neg_ff;
   logic [ProdBits-1:0]   prod_ff;
   logic                  neg2_ff;
   logic [MAG_BITS-1:0]   q0;
   logic [MAG_BITS:0]     rem;
   logic [MAG_BITS:0]     scaled;

   // constant quarter-wave table, one extra entry for full scale
   for (genvar g = 0; g <= TableSize; g++) begin : g_rom
      assign rom[g] = quarter_sine(g, TABLE_BITS);
   end

   // quadrant and index from the top phase bits
   assign quad     = phase[PHASE_BITS-1 -: 2];
   assign idx      = phase[PHASE_BITS-3 -: TABLE_BITS];
   assign rom_addr = quad[0] ? (TAW'(TableSize) - {1'b0, idx}) : {1'b0, idx};

   // stage 1: table read
   always_ff @(posedge clock) begin
      if (lookup) begin
         mag_ff <= rom[rom_addr];
         neg_ff <= quad[1];
      end
   end

   // stage 2: amplitude multiply
   always_ff @(posedge clock) begin
      prod_ff <= mag_ff * amplitude;
      neg2_ff <= neg_ff;
   end

   // divide by 32767: estimate by shift, one correction step
   assign q0     = prod_ff[ProdBits-1 -: MAG_BITS];
   assign rem    = {1'b0, prod_ff[MAG_BITS-1:0]} + {1'b0, q0};
   assign scaled = {1'b0, q0} + {{MAG_BITS{1'b0}}, (rem >= {1'b0, FULL_SCALE})};
   assign sample = neg2_ff ? (SAMPLE_BITS'(0) - scaled) : scaled;

endmodule

>>> sv/sine_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_generator: direct digital synthesis sine tone source
// Request channel (req_*) carries commands: a start loads a tone of
// req_tone_frequency Hz lasting req_duration_ms ms; a sample request returns
// one stereo beat on the response channel (rsp_*), silence when no tone runs.
// A start gives no response. Registers rate (0x0) and amplitude (0x4)
// sit on the APB-style port and are to be written only while the block is
// idle, a rule on the user that the block does not enforce. Phase, phase
// step and remaining count live in a three-word state memory; a sample
// request in a tone reads, updates and writes them back, a start writes
// all three; one command at a time. A sample request for silence skips
// the phase read and update; next request taken the cycle after the
// response loads. A start runs the bit-serial divider for the phase step;
// the count divides by 1000 by a registered and a reciprocal multiply.
// Reset (synchronous) returns to idle, empties the response register, sets
// the registers to 44100 and 19661 and marks all state words as zero.
// A stalled response holds; the block still takes the next request into its
// sequencer, and stops before loading a new response until the old one leaves.
// ----------------------------------------------------------------------------
module sine_tone_generator #(
   parameter int unsigned SINE_TABLE_BITS = sts_pkg::SINE_TABLE_BITS_DEF,
   parameter int unsigned PHASE_BITS      = sts_pkg::PHASE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [sts_pkg::FREQ_BITS-1:0]          req_tone_frequency,
   input  logic [sts_pkg::DUR_BITS-1:0]           req_duration_ms,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sts_pkg::SAMPLE_BITS-1:0] rsp_left_sample,
   output logic signed [sts_pkg::SAMPLE_BITS-1:0] rsp_right_sample,
   output logic                                   rsp_tone_active,
   output logic                                   rsp_last_sample,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [sts_pkg::ADDR_BITS-1:0]          paddr,
   input  logic [sts_pkg::DATA_BITS-1:0]          pwdata,
   output logic [sts_pkg::DATA_BITS-1:0]          prdata,
   output logic                                   pready
);

   import sts_pkg::*;

   localparam int unsigned DW = FREQ_BITS + PHASE_BITS;
   localparam int unsigned PW = RATE_BITS + DUR_BITS;
   localparam int unsigned RW = PW - MS_SHIFT + RECIP_BITS;

   state_type                       state_ff, state_in;
   logic [RATE_BITS-1:0]            rate_ff;
   logic [AMP_BITS-1:0]             amp_ff;
   logic [FREQ_BITS-1:0]            freq_ff;
   logic [DUR_BITS-1:0]             dur_ff;
   logic [COUNT_BITS-1:0]           cnt_ff, cnt_in;
   logic [PHASE_BITS-1:0]           acc_ff, acc_in;
   logic                            silent_ff, silent_in;
   logic [RAM_DEPTH-1:0]            entry_vld_ff;
   logic                            rd_vld_ff;
   logic                            rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]   rsp_sample_ff;
   logic                            rsp_active_ff;
   logic                            rsp_last_ff;
   logic                            req_take;
   logic                            rsp_free;
   logic                            rsp_load;
   logic                            csr_wr;

   logic                            ram_wr_en;
   logic [RAM_AW-1:0]               ram_wr_addr;
   logic [PHASE_BITS-1:0]           ram_wr_data;
   logic                            ram_rd_en;
   logic [RAM_AW-1:0]               ram_rd_addr;
   logic [PHASE_BITS-1:0]           ram_rd_data;
   logic [PHASE_BITS-1:0]           ram_q;

   logic                            div_start;
   logic [DW-1:0]                   div_dividend;
   logic [RATE_BITS-1:0]            div_divisor;
   logic                            div_done;
   logic [DW-1:0]                   div_quot;
   logic [PW-1:0]                   cnt_prod;
   logic [PW-1:0]                   cnt_prod_ff;
   logic [RW-1:0]                   cnt_recip;
   logic [COUNT_BITS-1:0]           cnt_sat;

   logic                            sine_lookup;
   logic signed [SAMPLE_BITS-1:0]   sine_sample;

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_RATE: prdata = DATA_BITS'(rate_ff);
         REG_AMP:  prdata = DATA_BITS'(amp_ff);
         default:  prdata = '0;
      endcase
   end

   // words not yet written read as zero
   assign ram_q = rd_vld_ff ? ram_rd_data : '0;

   // start count: rate times duration registered, then divided by 1000
   assign cnt_prod  = rate_ff * dur_ff;
   assign cnt_recip = cnt_prod_ff[PW-1:MS_SHIFT] * RECIP_125;
   assign cnt_sat   = (|cnt_recip[RW-1:RECIP_SHIFT+COUNT_BITS]) ? COUNT_MAX
                    : cnt_recip[RECIP_SHIFT+COUNT_BITS-1:RECIP_SHIFT];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      silent_in    = silent_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = SLOT_CNT;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = SLOT_CNT;
      ram_wr_data  = '0;
      div_start    = 1'b0;
      div_dividend = {freq_ff, {PHASE_BITS{1'b0}}};
      div_divisor  = rate_ff;
      sine_lookup  = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == CMD_START) begin
                  state_in = ST_CNT_GO;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = SLOT_CNT;
                  state_in    = ST_RD_ACC;
               end
            end
         end
         ST_RD_ACC: begin
            cnt_in    = ram_q[COUNT_BITS-1:0];
            silent_in = (ram_q[COUNT_BITS-1:0] == '0);
            if (ram_q[COUNT_BITS-1:0] == '0) begin
               state_in = ST_OUT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = SLOT_ACC;
               state_in    = ST_RD_STEP;
            end
         end
         ST_RD_STEP: begin
            acc_in      = ram_q;
            sine_lookup = 1'b1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = SLOT_STEP;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = SLOT_ACC;
            ram_wr_data = acc_ff + ram_q;
            state_in    = ST_WR_CNT;
         end
         ST_WR_CNT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = SLOT_CNT;
            ram_wr_data = PHASE_BITS'(cnt_ff - 1'b1);
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CNT_GO: begin
            state_in = ST_DIV_CNT;
         end
         ST_DIV_CNT: begin
            cnt_in   = cnt_sat;
            state_in = ST_STEP_GO;
         end
         ST_STEP_GO: begin
            div_start   = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = SLOT_CNT;
            ram_wr_data = PHASE_BITS'(cnt_ff);
            state_in    = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            if (div_done) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = SLOT_STEP;
               ram_wr_data = (rate_ff == '0) ? '0 : div_quot[PHASE_BITS-1:0];
               state_in    = ST_WR_ACC;
            end
         end
         ST_WR_ACC: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = SLOT_ACC;
            ram_wr_data = '0;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RESET;
         amp_ff       <= AMP_RESET;
         entry_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            unique case (reg_index_type'(paddr[2]))
               REG_RATE: rate_ff <= pwdata[RATE_BITS-1:0];
               REG_AMP:  amp_ff  <= pwdata[AMP_BITS-1:0];
               default:  rate_ff <= rate_ff;
            endcase
         end
         if (ram_wr_en) begin
            entry_vld_ff[ram_wr_addr] <= 1'b1;
         end
         if (ram_rd_en) begin
            rd_vld_ff <= entry_vld_ff[ram_rd_addr];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers and response beat
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      silent_ff   <= silent_in;
      cnt_prod_ff <= cnt_prod;
      if (req_take) begin
         freq_ff <= req_tone_frequency;
         dur_ff  <= req_duration_ms;
      end
      if (rsp_load) begin
         rsp_sample_ff <= silent_ff ? '0 : sine_sample;
         rsp_active_ff <= !silent_ff;
         rsp_last_ff   <= !silent_ff && (cnt_ff == COUNT_BITS'(1));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_sample_ff;
   assign rsp_right_sample = rsp_sample_ff;
   assign rsp_tone_active  = rsp_active_ff;
   assign rsp_last_sample  = rsp_last_ff;

   // state memory: phase, phase step, remaining count
   sts_ram #(
      .WIDTH (PHASE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // bit-serial divider for the phase step
   sts_div #(
      .DW (DW),
      .VW (RATE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // sine lookup, sample ready after the table read and multiply registers
   sts_sine #(
      .TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS (PHASE_BITS)
   ) u_sine (
      .clock     (clock),
      .lookup    (sine_lookup),
      .phase     (ram_q),
      .amplitude (amp_ff),
      .sample    (sine_sample)
   );

endmodule

>>> sv/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker: port-level checks for the sine tone generator
// Watches the response channel over time; bound to the top level below.
// ----------------------------------------------------------------------------
module sts_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_left_sample,
   input logic signed [15:0] rsp_right_sample,
   input logic               rsp_tone_active,
   input logic               rsp_last_sample
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_sample) &&
      $stable(rsp_tone_active) && $stable(rsp_last_sample))
      else $error("stalled response beat changed");

   // both channels carry the same sample
   a_stereo_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_sample == rsp_right_sample)
      else $error("left and right samples differ");

   // silence is all zero and never marked last
   a_silence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tone_active |-> rsp_left_sample == 16'sd0 && !rsp_last_sample)
      else $error("silence beat not zero");

   // response register empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sine_tone_generator sts_checker u_sts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_left_sample  (rsp_left_sample),
   .rsp_right_sample (rsp_right_sample),
   .rsp_tone_active  (rsp_tone_active),
   .rsp_last_sample  (rsp_last_sample)
);
